// File: rtl/cdqs_pkg.sv
// Shared types and codes for the circular deque with search.
package cdqs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int POS_W         = 5;
   localparam int DATA_W        = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_DUMP       = 3'd5,
      OP_REVERSE    = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  value_res;
      logic [POS_W-1:0]          position;
      logic [POS_W-1:0]          count;
      logic                      empty_res;
      logic                      last;
   } rsp_type;

endpackage

// File: rtl/circular_deque_with_search_unit.sv
// Bounded double-ended queue in a ring buffer, with search and dump walks.
//
//  channel   ports                         direction  handshake
//  request   start, busy, req_item         in         taken when start & !busy
//  response  rsp_valid, rsp_item           out        one-cycle strobe, no stall
//
// Push, reverse and clear finish in the execute state, pops add a read state, and dump and
// search walk the stored entries. The walks are set by the single RAM read
// port, which delivers one stored entry per cycle to one shared comparator.
// Reset (synchronous) empties the queue; entry contents are not cleared.
// busy stays high from the accepting edge until the last response is registered;
// a new transaction can be taken while that last response is on the ports.
module circular_deque_with_search_unit #(
   parameter int DEPTH = cdqs_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdqs_pkg::req_type req_item,
   output logic              rsp_valid,
   output cdqs_pkg::rsp_type rsp_item
);

   import cdqs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [DATA_W-1:0]       key_ff, key_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rev_ff, rev_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]        pend_pos_ff, pend_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // Address unit: logical position to physical slot.
   logic [CNT_W-1:0]        addr_pos;
   logic [CNT_W-1:0]        off_cnt;
   logic [IDX_W:0]          slot_sum;
   logic [IDX_W-1:0]        slot;
   logic [IDX_W:0]          hi_sum;
   logic [IDX_W-1:0]        hi_slot;
   logic [IDX_W-1:0]        head_dec;
   logic [IDX_W-1:0]        head_inc;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic                    ram_rd_en;
   logic [DATA_W-1:0]       ram_rd_data;

   logic                    is_empty;
   logic                    is_full;
   logic                    low_end;
   logic [CNT_W-1:0]        pos_nxt;
   logic                    walk_end;
   logic                    match;

   function automatic rsp_type make_rsp(status_type st, logic [DATA_W-1:0] val,
                                        logic [CNT_W-1:0] pos, logic [CNT_W-1:0] cnt,
                                        logic lst);
      rsp_type r;
      r.status    = st;
      r.value_res = val;
      r.position  = POS_W'(pos);
      r.count     = POS_W'(cnt);
      r.empty_res = (cnt == '0);
      r.last      = lst;
      return r;
   endfunction

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign pos_nxt  = pos_ff + CNT_W'(1);
   assign walk_end = (pos_nxt == count_ff);
   assign match    = (ram_rd_data == key_ff);

   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   always_comb begin
      if (state_ff == ST_WALK) begin
         addr_pos = pos_nxt;
      end else if (op_ff == OP_POP_BACK) begin
         addr_pos = count_ff - CNT_W'(1);
      end else begin
         addr_pos = '0;
      end
      off_cnt  = rev_ff ? (count_ff - CNT_W'(1) - addr_pos) : addr_pos;
      slot_sum = {1'b0, head_ff} + {1'b0, IDX_W'(off_cnt)};
      if (slot_sum >= (IDX_W + 1)'(DEPTH)) begin
         slot = IDX_W'(slot_sum - (IDX_W + 1)'(DEPTH));
      end else begin
         slot = IDX_W'(slot_sum);
      end
      // Only used when the queue is not full, so count fits the index width.
      hi_sum = {1'b0, head_ff} + {1'b0, IDX_W'(count_ff)};
      if (hi_sum >= (IDX_W + 1)'(DEPTH)) begin
         hi_slot = IDX_W'(hi_sum - (IDX_W + 1)'(DEPTH));
      end else begin
         hi_slot = IDX_W'(hi_sum);
      end
   end

   // A push lands at the low physical end when its side and the direction bit disagree.
   assign low_end     = (op_ff == OP_PUSH_FRONT) != rev_ff;
   assign ram_wr_addr = low_end ? head_dec : hi_slot;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.operation;
               key_in   = req_item.value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (is_full) begin
                     rsp_in = make_rsp(STATUS_FULL, '0, '0, count_ff, 1'b1);
                  end else begin
                     ram_wr_en = 1'b1;
                     if (low_end) begin
                        head_in = head_dec;
                     end
                     count_in = count_ff + CNT_W'(1);
                     rsp_in   = make_rsp(STATUS_OK, '0, '0, count_in, 1'b1);
                  end
                  rsp_valid_in = 1'b1;
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (is_empty) begin
                     rsp_in       = make_rsp(STATUS_EMPTY, '0, '0, count_ff, 1'b1);
                     rsp_valid_in = 1'b1;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_POP;
                  end
               end
               OP_SEARCH, OP_DUMP: begin
                  if (is_empty) begin
                     rsp_in       = make_rsp(STATUS_EMPTY, '0, '0, count_ff, 1'b1);
                     rsp_valid_in = 1'b1;
                  end else begin
                     ram_rd_en     = 1'b1;
                     pos_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_WALK;
                  end
               end
               OP_REVERSE: begin
                  if (is_empty) begin
                     rsp_in = make_rsp(STATUS_EMPTY, '0, '0, count_ff, 1'b1);
                  end else begin
                     rev_in = !rev_ff;
                     rsp_in = make_rsp(STATUS_OK, '0, '0, count_ff, 1'b1);
                  end
                  rsp_valid_in = 1'b1;
               end
               default: begin
                  count_in     = '0;
                  head_in      = '0;
                  rev_in       = 1'b0;
                  rsp_in       = make_rsp(is_empty ? STATUS_EMPTY : STATUS_OK,
                                          '0, '0, '0, 1'b1);
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_POP: begin
            if ((op_ff == OP_POP_FRONT) != rev_ff) begin
               head_in = head_inc;
            end
            count_in     = count_ff - CNT_W'(1);
            rsp_in       = make_rsp(STATUS_OK, ram_rd_data, '0, count_in, 1'b1);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            ram_rd_en = !walk_end;
            pos_in    = pos_nxt;
            if (op_ff == OP_DUMP) begin
               rsp_in       = make_rsp(STATUS_OK, ram_rd_data, pos_nxt, count_ff, walk_end);
               rsp_valid_in = 1'b1;
               if (walk_end) begin
                  state_in = ST_IDLE;
               end
            end else begin
               // A match is held back until the next match or the flush, so the final one can carry last.
               if (match) begin
                  if (pend_valid_ff) begin
                     rsp_in       = make_rsp(STATUS_OK, key_ff, pend_pos_ff, count_ff, 1'b0);
                     rsp_valid_in = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_pos_in   = pos_nxt;
               end
               if (walk_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_in = make_rsp(STATUS_OK, key_ff, pend_pos_ff, count_ff, 1'b1);
            end else begin
               rsp_in = make_rsp(STATUS_NOT_FOUND, '0, '0, count_ff, 1'b1);
            end
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rev_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rev_ff        <= rev_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      pend_pos_ff <= pend_pos_in;
      rsp_ff      <= rsp_in;
   end

   cdqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/cdqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/deque_checker.sv
// Checker for the deque unit: predicts every response and compares it on the fly.
`timescale 1ns / 1ps

module deque_checker #(
   parameter int DEPTH = cdqs_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cdqs_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  cdqs_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                pending,
   output int                items_taken,
   output int                results_checked
);
   import cdqs_pkg::*;

   logic signed [DATA_W-1:0] slots [DEPTH];
   int unsigned              head;
   int unsigned              fill;
   bit                       flipped;

   rsp_type                  awaited_results [$];
   int                       mismatches;
   int                       taken;
   int                       checked;

   assign fail_count      = mismatches;
   assign pending         = awaited_results.size();
   assign items_taken     = taken;
   assign results_checked = checked;

   // Maps a position counted from the logical front to a ring slot.
   function automatic int unsigned slot_of(int unsigned p);
      int unsigned off;
      off = flipped ? (fill - 1 - p) : p;
      return (head + off) % DEPTH;
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic signed [DATA_W-1:0] val,
                                        int unsigned pos);
      rsp_type r;
      r.status    = st;
      r.value_res = val;
      r.position  = POS_W'(pos);
      r.count     = POS_W'(fill);
      r.empty_res = (fill == 0);
      r.last      = 1'b0;
      return r;
   endfunction

   task automatic predict_deque_op(req_type item);
      rsp_type                  batch [DEPTH];
      int                       n;
      int unsigned              p;
      logic signed [DATA_W-1:0] val;
      status_type               st;
      n = 0;
      case (item.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               batch[n++] = make_rsp(STATUS_FULL, '0, 0);
            end else begin
               if ((item.operation == OP_PUSH_FRONT) != flipped) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slots[head] = item.value;
               end else begin
                  slots[(head + fill) % DEPTH] = item.value;
               end
               fill++;
               batch[n++] = make_rsp(STATUS_OK, '0, 0);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (fill == 0) begin
               batch[n++] = make_rsp(STATUS_EMPTY, '0, 0);
            end else begin
               p = (item.operation == OP_POP_FRONT) ? 0 : fill - 1;
               val = slots[slot_of(p)];
               if ((item.operation == OP_POP_FRONT) != flipped) head = (head + 1) % DEPTH;
               fill--;
               batch[n++] = make_rsp(STATUS_OK, val, 0);
            end
         end
         OP_SEARCH: begin
            if (fill == 0) begin
               batch[n++] = make_rsp(STATUS_EMPTY, '0, 0);
            end else begin
               for (p = 0; p < fill; p++)
                  if (slots[slot_of(p)] == item.value)
                     batch[n++] = make_rsp(STATUS_OK, item.value, p + 1);
               if (n == 0) batch[n++] = make_rsp(STATUS_NOT_FOUND, '0, 0);
            end
         end
         OP_DUMP: begin
            if (fill == 0) begin
               batch[n++] = make_rsp(STATUS_EMPTY, '0, 0);
            end else begin
               for (p = 0; p < fill; p++)
                  batch[n++] = make_rsp(STATUS_OK, slots[slot_of(p)], p + 1);
            end
         end
         OP_REVERSE: begin
            if (fill == 0) begin
               batch[n++] = make_rsp(STATUS_EMPTY, '0, 0);
            end else begin
               flipped = !flipped;
               batch[n++] = make_rsp(STATUS_OK, '0, 0);
            end
         end
         default: begin
            // Clear puts the ring back to its reset shape even when already empty.
            st = (fill == 0) ? STATUS_EMPTY : STATUS_OK;
            fill = 0;
            head = 0;
            flipped = 1'b0;
            batch[n++] = make_rsp(st, '0, 0);
         end
      endcase
      batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) awaited_results.push_back(batch[i]);
   endtask

   task automatic report_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: response with nothing expected, expected none, actual %p", $time, got);
         mismatches++;
         return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.status !== want.status) report_mismatch("status", want.status, got.status);
      if (got.value_res !== want.value_res)
         report_mismatch("value_res", want.value_res, got.value_res);
      if (got.position !== want.position)
         report_mismatch("position", want.position, got.position);
      if (got.count !== want.count) report_mismatch("count", want.count, got.count);
      if (got.empty_res !== want.empty_res)
         report_mismatch("empty_res", want.empty_res, got.empty_res);
      if (got.last !== want.last) report_mismatch("last", want.last, got.last);
   endtask

   initial begin
      mismatches = 0;
      taken      = 0;
      checked    = 0;
      head       = 0;
      fill       = 0;
      flipped    = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         head    = 0;
         fill    = 0;
         flipped = 1'b0;
         for (int i = 0; i < DEPTH; i++) slots[i] = '0;
         awaited_results.delete();
      end else begin
         // A response leaving at this edge belongs to an older transaction.
         if (rsp_valid) check_response(rsp_item);
         if (start && !busy) begin
            taken++;
            predict_deque_op(req_item);
         end
      end
   end

endmodule

// File: bench/tb_circular_deque_with_search_unit.sv
// Top of the deque testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_circular_deque_with_search_unit;
   import cdqs_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   int fail_count;
   int pending;
   int items_taken;
   int results_checked;
   int burst_left = 0;

   circular_deque_with_search_unit #(.DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   deque_checker #(.DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_item        (rsp_item),
      .fail_count      (fail_count),
      .pending         (pending),
      .items_taken     (items_taken),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Small values repeat often so that searches find one or more matches.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return DATA_W'($urandom_range(1, 4)) - 2;
         6, 7, 8:          return $urandom;
         default:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   // Returns at the edge that takes the transaction; start stays high so the
   // next one can follow back to back.
   task automatic issue(op_type op, logic signed [DATA_W-1:0] v);
      req_type item;
      int      gap;
      gap = (burst_left > 0) ? 0 : $urandom_range(0, 7);
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.operation = op;
      item.value     = v;
      start    <= 1'b1;
      req_item <= item;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      int   r;
      bit   growing;
      op_type op;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Pops, search, dump, reverse and clear on an empty queue.
      issue(OP_POP_FRONT, 0);
      issue(OP_POP_BACK, 0);
      issue(OP_SEARCH, 0);
      issue(OP_DUMP, 0);
      issue(OP_REVERSE, 0);
      issue(OP_CLEAR, 0);
      // Extremes of the value field, both ends, duplicates for search.
      issue(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      issue(OP_PUSH_BACK, 32'h8000_0000);
      issue(OP_PUSH_FRONT, -1);
      issue(OP_PUSH_BACK, 0);
      issue(OP_PUSH_BACK, -1);
      issue(OP_SEARCH, -1);
      issue(OP_SEARCH, 12345);
      issue(OP_DUMP, 0);
      issue(OP_REVERSE, 0);
      issue(OP_DUMP, 0);
      issue(OP_POP_FRONT, 0);
      issue(OP_POP_BACK, 0);
      issue(OP_CLEAR, 0);
      // Clear on an empty but reversed queue must restore the normal direction.
      issue(OP_PUSH_BACK, 11);
      issue(OP_REVERSE, 0);
      issue(OP_POP_FRONT, 0);
      issue(OP_CLEAR, 0);
      issue(OP_PUSH_FRONT, 12);
      issue(OP_PUSH_BACK, 13);
      issue(OP_DUMP, 0);
      // Fill to the top, then push into a full queue.
      for (int i = 0; i < DEPTH - 2; i++) issue(OP_PUSH_BACK, pick_value());
      issue(OP_PUSH_FRONT, 99);
      issue(OP_PUSH_BACK, 98);
      issue(OP_SEARCH, 1);
      issue(OP_DUMP, 0);
      drain();

      // Random part: phases that lean toward growing or shrinking the queue.
      growing = 1'b1;
      for (int i = 0; i < 86; i++) begin
         if (i % 24 == 0) growing = !growing;
         if (burst_left == 0 && $urandom_range(0, 9) == 0) burst_left = 10;
         r = $urandom_range(0, 99);
         if (r < 30)      op = growing ? OP_PUSH_FRONT : OP_POP_FRONT;
         else if (r < 60) op = growing ? OP_PUSH_BACK : OP_POP_BACK;
         else if (r < 67) op = growing ? OP_POP_FRONT : OP_PUSH_FRONT;
         else if (r < 74) op = growing ? OP_POP_BACK : OP_PUSH_BACK;
         else if (r < 86) op = OP_SEARCH;
         else if (r < 92) op = OP_DUMP;
         else if (r < 98) op = OP_REVERSE;
         else             op = OP_CLEAR;
         issue(op, pick_value());
         if (i == 65) drain();
      end

      drain();
      repeat (25) @(posedge clock);
      $display("Run took %0d transactions and checked %0d responses,", items_taken,
               results_checked);
      $display("covering all eight operations on empty, partly filled and full queues.");
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
rtl/cdqs_pkg.sv
rtl/cdqs_ram.sv
rtl/circular_deque_with_search_unit.sv
bench/deque_checker.sv
bench/tb_circular_deque_with_search_unit.sv
